// ----- design/gsc_pkg.sv -----
// ============================================================================
// gsc_pkg: shared types and constants
// Calibration tables, flag bit positions, CSR indices, divider widths and the divider transaction structs.
// ============================================================================
package gsc_pkg;

   localparam int CURVE_POINTS    = 19;
   localparam int TEMP_POINTS     = 6;
   localparam int HUMIDITY_POINTS = 5;

   localparam int CURVE_IDX_W = $clog2(CURVE_POINTS);
   localparam int TEMP_IDX_W  = $clog2(TEMP_POINTS);
   localparam int HUM_IDX_W   = $clog2(HUMIDITY_POINTS);

   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 21;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam int FLAG_LOW_BIT    = 0;
   localparam int FLAG_HIGH_BIT   = 1;
   localparam int FLAG_T_HIGH_BIT = 2;
   localparam int FLAG_T_LOW_BIT  = 3;
   localparam int FLAG_H_HIGH_BIT = 4;
   localparam int FLAG_H_LOW_BIT  = 5;

   localparam logic [13:0] CURVE_PPM [CURVE_POINTS] = '{
      14'd500, 14'd600, 14'd700, 14'd800, 14'd900, 14'd1000, 14'd1300, 14'd1700,
      14'd2000, 14'd2100, 14'd3000, 14'd4000, 14'd4400, 14'd5000, 14'd6000,
      14'd7000, 14'd8000, 14'd9000, 14'd10000};

   localparam logic [15:0] CURVE_RATIO [CURVE_POINTS] = '{
      16'd6144, 16'd5734, 16'd5325, 16'd4915, 16'd4506, 16'd4096, 16'd3686,
      16'd3277, 16'd2990, 16'd2867, 16'd2458, 16'd2171, 16'd2048, 16'd1925,
      16'd1761, 16'd1679, 16'd1556, 16'd1475, 16'd1434};

   localparam logic signed [7:0] TEMP_AXIS [TEMP_POINTS] = '{
      -8'sd10, 8'sd0, 8'sd10, 8'sd20, 8'sd30, 8'sd40};

   localparam logic [7:0] HUM_AXIS [HUMIDITY_POINTS] = '{
      8'd0, 8'd20, 8'd40, 8'd65, 8'd100};

   localparam logic [12:0] COMP_TABLE [HUMIDITY_POINTS][TEMP_POINTS] = '{
      '{13'd7660, 13'd7332, 13'd7127, 13'd6881, 13'd6758, 13'd6595},
      '{13'd7086, 13'd6226, 13'd5530, 13'd4956, 13'd4588, 13'd4383},
      '{13'd6881, 13'd5939, 13'd5120, 13'd4506, 13'd4014, 13'd3768},
      '{13'd6595, 13'd5530, 13'd4710, 13'd4096, 13'd3686, 13'd3523},
      '{13'd6349, 13'd5325, 13'd4506, 13'd3932, 13'd3523, 13'd3400}};

   typedef enum logic [2:0] {
      CSR_SUPPLY,
      CSR_LOAD_RES,
      CSR_WIRE_DROP,
      CSR_BASE_RES,
      CSR_TEMP_HIGH,
      CSR_TEMP_LOW,
      CSR_HUM_HIGH,
      CSR_HUM_LOW
   } csr_index_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

// ----- design/gsc_div.sv -----
// ============================================================================
// gsc_div: shared restoring divider
// Unsigned long division, one quotient bit per cycle, done pulses when ready.
// ============================================================================
module gsc_div (
   input  logic                clock,
   input  logic                reset,
   input  gsc_pkg::div_req_type div_req,
   output gsc_pkg::div_rsp_type div_rsp
);
   import gsc_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = num_ff;

endmodule

// ----- design/gas_sensor_ppm_compensation_core.sv -----
// A zero-voltage sample makes three passes through the shared divider; any other
// sample makes up to six passes, plus a curve search. One transaction at a time;
// the next is accepted once the result is registered. Synchronous active-high
// reset clears control state and loads the default calibration.
// ============================================================================
// gas_sensor_ppm_compensation_core: gas ppm with temp/humidity compensation
// Sequencer around a shared divider: bilinear R0, Rs, ratio, curve lookup.
// ============================================================================
module gas_sensor_ppm_compensation_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_load_millivolts,
   input  logic signed [7:0]  req_temperature,
   input  logic [7:0]         req_humidity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_concentration_ppm,
   output logic [5:0]         rsp_range_flags,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_write_data
);
   import gsc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_LERP_GO, S_LERP_WAIT, S_R0, S_RS_GO, S_RS_WAIT,
      S_RATIO_GO, S_RATIO_WAIT, S_SEARCH, S_PPM_GO, S_PPM_WAIT, S_DONE
   } state_type;

   // configuration
   logic [15:0]       supply_ff;
   logic [19:0]       load_res_ff;
   logic [9:0]        wire_ff;
   logic [19:0]       base_ff;
   logic signed [6:0] t_hi_ff, t_lo_ff;
   logic [6:0]        h_hi_ff, h_lo_ff;

   state_type state_ff, state_in;
   logic [16:0]             v_ff, v_in;
   logic signed [7:0]       t_ff, t_in;
   logic [7:0]              h_ff, h_in;
   logic [5:0]              flags_ff, flags_in;
   logic [12:0]             c00_ff, c00_in, c10_ff, c10_in, c01_ff, c01_in, c11_ff, c11_in;
   logic [5:0]              dxh_ff, dxh_in, spanh_ff, spanh_in, dxt_ff, dxt_in, spant_ff, spant_in;
   logic [1:0]              lidx_ff, lidx_in;
   logic                    neg_ff, neg_in;
   logic signed [14:0]      y1_ff, y1_in;
   logic signed [14:0]      ya_ff, ya_in, yb_ff, yb_in, factor_ff, factor_in;
   logic [20:0]             r0_ff, r0_in;
   logic [35:0]             rs_ff, rs_in;
   logic [15:0]             ratio_ff, ratio_in;
   logic [CURVE_IDX_W-1:0]  ci_ff, ci_in;
   logic [13:0]             ppm_ff, ppm_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [13:0]             rsp_ppm_ff, rsp_ppm_in;
   logic [5:0]              rsp_flags_ff, rsp_flags_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [TEMP_IDX_W-1:0] t_seg, t_seg_n;
   logic [HUM_IDX_W-1:0]  h_seg, h_seg_n;
   logic signed [7:0]     t_sel;
   logic [7:0]            h_sel;
   logic                  t_high, t_low, h_high, h_low;
   logic signed [14:0]    ly1, ly2;
   logic [5:0]            ldx, lspan;
   logic signed [15:0]    ldiff;
   logic signed [22:0]    lprod;
   logic [22:0]           lmag;
   logic signed [14:0]    lres;
   logic [12:0]           factor_pos;
   logic [32:0]           r0_sum;
   logic [20:0]           r0_raw;
   logic [16:0]           vdiff;
   logic [36:0]           rs_num;
   logic [29:0]           ppm_num;
   logic [CURVE_IDX_W-1:0] ci_n;

   gsc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      t_seg = TEMP_IDX_W'(TEMP_POINTS - 2);
      for (int i = TEMP_POINTS - 3; i >= 0; i--) begin
         if (t_ff <= TEMP_AXIS[i+1]) t_seg = TEMP_IDX_W'(i);
      end
      h_seg = HUM_IDX_W'(HUMIDITY_POINTS - 2);
      for (int i = HUMIDITY_POINTS - 3; i >= 0; i--) begin
         if (h_ff <= HUM_AXIS[i+1]) h_seg = HUM_IDX_W'(i);
      end
      t_seg_n = t_seg + 1'b1;
      h_seg_n = h_seg + 1'b1;
   end

   always_comb begin
      t_high = (req_temperature > TEMP_AXIS[TEMP_POINTS-1]);
      t_low  = (req_temperature < TEMP_AXIS[0]);
      if (t_high)     t_sel = {t_hi_ff[6], t_hi_ff};
      else if (t_low) t_sel = {t_lo_ff[6], t_lo_ff};
      else            t_sel = req_temperature;
      h_high = (req_humidity > HUM_AXIS[HUMIDITY_POINTS-1]);
      h_low  = (req_humidity < HUM_AXIS[0]);
      if (h_high)     h_sel = {1'b0, h_hi_ff};
      else if (h_low) h_sel = {1'b0, h_lo_ff};
      else            h_sel = req_humidity;
   end

   always_comb begin
      case (lidx_ff)
         2'd0: begin
            ly1 = $signed({2'b00, c00_ff});
            ly2 = $signed({2'b00, c10_ff});
            ldx = dxh_ff;
            lspan = spanh_ff;
         end
         2'd1: begin
            ly1 = $signed({2'b00, c01_ff});
            ly2 = $signed({2'b00, c11_ff});
            ldx = dxh_ff;
            lspan = spanh_ff;
         end
         default: begin
            ly1 = ya_ff;
            ly2 = yb_ff;
            ldx = dxt_ff;
            lspan = spant_ff;
         end
      endcase
      ldiff = {ly2[14], ly2} - {ly1[14], ly1};
      lprod = ldiff * $signed({1'b0, ldx});
      lmag  = lprod[22] ? 23'(-lprod) : 23'(lprod);
      lres  = neg_ff ? y1_ff - $signed({1'b0, div_rsp.quot[13:0]})
                     : y1_ff + $signed({1'b0, div_rsp.quot[13:0]});
      factor_pos = factor_ff[14] ? 13'd0 : factor_ff[12:0];
      r0_sum  = ({20'd0, factor_pos} * {13'd0, base_ff}) + 33'd2048;
      r0_raw  = r0_sum[32:12];
      vdiff   = {1'b0, supply_ff} - v_ff;
      rs_num  = vdiff * load_res_ff;
      ci_n    = ci_ff + 1'b1;
      ppm_num = (CURVE_PPM[ci_n] - CURVE_PPM[ci_ff]) * (CURVE_RATIO[ci_ff] - ratio_ff);
   end

   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      t_in      = t_ff;
      h_in      = h_ff;
      flags_in  = flags_ff;
      c00_in    = c00_ff;
      c10_in    = c10_ff;
      c01_in    = c01_ff;
      c11_in    = c11_ff;
      dxh_in    = dxh_ff;
      spanh_in  = spanh_ff;
      dxt_in    = dxt_ff;
      spant_in  = spant_ff;
      lidx_in   = lidx_ff;
      neg_in    = neg_ff;
      y1_in     = y1_ff;
      ya_in     = ya_ff;
      yb_in     = yb_ff;
      factor_in = factor_ff;
      r0_in     = r0_ff;
      rs_in     = rs_ff;
      ratio_in  = ratio_ff;
      ci_in     = ci_ff;
      ppm_in    = ppm_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_ppm_in   = rsp_ppm_ff;
      rsp_flags_in = rsp_flags_ff;
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               v_in = {1'b0, req_load_millivolts} + {7'd0, wire_ff};
               if (t_sel > TEMP_AXIS[TEMP_POINTS-1])  t_in = TEMP_AXIS[TEMP_POINTS-1];
               else if (t_sel < TEMP_AXIS[0])         t_in = TEMP_AXIS[0];
               else                                   t_in = t_sel;
               if (h_sel > HUM_AXIS[HUMIDITY_POINTS-1]) h_in = HUM_AXIS[HUMIDITY_POINTS-1];
               else if (h_sel < HUM_AXIS[0])            h_in = HUM_AXIS[0];
               else                                     h_in = h_sel;
               flags_in = '0;
               flags_in[FLAG_T_HIGH_BIT] = t_high;
               flags_in[FLAG_T_LOW_BIT]  = t_low & ~t_high;
               flags_in[FLAG_H_HIGH_BIT] = h_high;
               flags_in[FLAG_H_LOW_BIT]  = h_low & ~h_high;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            c00_in   = COMP_TABLE[h_seg][t_seg];
            c10_in   = COMP_TABLE[h_seg_n][t_seg];
            c01_in   = COMP_TABLE[h_seg][t_seg_n];
            c11_in   = COMP_TABLE[h_seg_n][t_seg_n];
            dxh_in   = 6'(h_ff - HUM_AXIS[h_seg]);
            spanh_in = 6'(HUM_AXIS[h_seg_n] - HUM_AXIS[h_seg]);
            dxt_in   = 6'(t_ff - TEMP_AXIS[t_seg]);
            spant_in = 6'(TEMP_AXIS[t_seg_n] - TEMP_AXIS[t_seg]);
            lidx_in  = 2'd0;
            state_in = S_LERP_GO;
         end
         S_LERP_GO: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(lmag) + DIV_NUM_W'(lspan >> 1);
            div_req.den   = DIV_DEN_W'(lspan);
            neg_in   = lprod[22];
            y1_in    = ly1;
            state_in = S_LERP_WAIT;
         end
         S_LERP_WAIT: begin
            if (div_rsp.done) begin
               case (lidx_ff)
                  2'd0:    ya_in = lres;
                  2'd1:    yb_in = lres;
                  default: factor_in = lres;
               endcase
               if (lidx_ff == 2'd2) begin
                  state_in = S_R0;
               end else begin
                  lidx_in  = lidx_ff + 1'b1;
                  state_in = S_LERP_GO;
               end
            end
         end
         S_R0: begin
            r0_in = (r0_raw == '0) ? 21'd1 : r0_raw;
            if (v_ff == '0) begin
               flags_in[FLAG_LOW_BIT] = 1'b1;
               ppm_in   = '0;
               state_in = S_DONE;
            end else if (v_ff >= {1'b0, supply_ff}) begin
               rs_in    = '0;
               state_in = S_RATIO_GO;
            end else begin
               state_in = S_RS_GO;
            end
         end
         S_RS_GO: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(rs_num);
            div_req.den   = DIV_DEN_W'(v_ff);
            state_in = S_RS_WAIT;
         end
         S_RS_WAIT: begin
            if (div_rsp.done) begin
               rs_in    = div_rsp.quot[35:0];
               state_in = S_RATIO_GO;
            end
         end
         S_RATIO_GO: begin
            if ({4'd0, rs_ff} >= {19'd0, r0_ff, 4'd0}) begin
               ratio_in = 16'hFFFF;
               ci_in    = '0;
               state_in = S_SEARCH;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DIV_NUM_W'({rs_ff, 12'd0});
               div_req.den   = r0_ff;
               state_in = S_RATIO_WAIT;
            end
         end
         S_RATIO_WAIT: begin
            if (div_rsp.done) begin
               ratio_in = div_rsp.quot[15:0];
               ci_in    = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (ratio_ff > CURVE_RATIO[0]) begin
               flags_in[FLAG_LOW_BIT] = 1'b1;
               ppm_in   = '0;
               state_in = S_DONE;
            end else if (ratio_ff < CURVE_RATIO[CURVE_POINTS-1]) begin
               flags_in[FLAG_HIGH_BIT] = 1'b1;
               ppm_in   = CURVE_PPM[CURVE_POINTS-1];
               state_in = S_DONE;
            end else if (ci_ff < CURVE_IDX_W'(CURVE_POINTS - 2) &&
                         !(ratio_ff > CURVE_RATIO[ci_n])) begin
               ci_in = ci_n;
            end else begin
               state_in = S_PPM_GO;
            end
         end
         S_PPM_GO: begin
            if (CURVE_RATIO[ci_ff] == CURVE_RATIO[ci_n]) begin
               ppm_in   = CURVE_PPM[ci_ff];
               state_in = S_DONE;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DIV_NUM_W'(ppm_num);
               div_req.den   = DIV_DEN_W'(CURVE_RATIO[ci_ff] - CURVE_RATIO[ci_n]);
               state_in = S_PPM_WAIT;
            end
         end
         S_PPM_WAIT: begin
            if (div_rsp.done) begin
               ppm_in   = CURVE_PPM[ci_ff] + div_rsp.quot[13:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ppm_in   = ppm_ff;
               rsp_flags_in = flags_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         supply_ff    <= 16'd5000;
         load_res_ff  <= 20'd10000;
         wire_ff      <= 10'd0;
         base_ff      <= 20'd10000;
         t_hi_ff      <= 7'sd40;
         t_lo_ff      <= -7'sd10;
         h_hi_ff      <= 7'd100;
         h_lo_ff      <= 7'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_SUPPLY:    supply_ff   <= csr_write_data[15:0];
               CSR_LOAD_RES:  load_res_ff <= csr_write_data;
               CSR_WIRE_DROP: wire_ff     <= csr_write_data[9:0];
               CSR_BASE_RES:  base_ff     <= csr_write_data;
               CSR_TEMP_HIGH: t_hi_ff     <= $signed(csr_write_data[6:0]);
               CSR_TEMP_LOW:  t_lo_ff     <= $signed(csr_write_data[6:0]);
               CSR_HUM_HIGH:  h_hi_ff     <= csr_write_data[6:0];
               CSR_HUM_LOW:   h_lo_ff     <= csr_write_data[6:0];
               default: ;
            endcase
         end
      end
      v_ff      <= v_in;
      t_ff      <= t_in;
      h_ff      <= h_in;
      flags_ff  <= flags_in;
      c00_ff    <= c00_in;
      c10_ff    <= c10_in;
      c01_ff    <= c01_in;
      c11_ff    <= c11_in;
      dxh_ff    <= dxh_in;
      spanh_ff  <= spanh_in;
      dxt_ff    <= dxt_in;
      spant_ff  <= spant_in;
      lidx_ff   <= lidx_in;
      neg_ff    <= neg_in;
      y1_ff     <= y1_in;
      ya_ff     <= ya_in;
      yb_ff     <= yb_in;
      factor_ff <= factor_in;
      r0_ff     <= r0_in;
      rs_ff     <= rs_in;
      ratio_ff  <= ratio_in;
      ci_ff     <= ci_in;
      ppm_ff    <= ppm_in;
      rsp_ppm_ff   <= rsp_ppm_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_concentration_ppm = rsp_ppm_ff;
   assign rsp_range_flags       = rsp_flags_ff;

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_SETUP))
      else $error("accepted transaction did not start setup");

   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside done state");

endmodule
